FILE: rtl/wdvf_pkg.sv
// ----------------------------------------------------------------------------
// wdvf_pkg
// Shared types and constants for the windowed detection vote fusion block.
// ----------------------------------------------------------------------------
package wdvf_pkg;

    localparam int CLASS_W = 4;
    localparam int CONF_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VOTE_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CONF_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_VOTE_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_CONF_MIN = 3'd4;

    localparam logic       REQ_STORE     = 1'b0;
    localparam logic       REQ_CORRELATE = 1'b1;
    localparam logic [1:0] ALERT_LOW     = 2'd0;
    localparam logic [1:0] ALERT_MEDIUM  = 2'd1;
    localparam logic [1:0] ALERT_HIGH    = 2'd2;
    localparam logic [3:0] MEAN_MAX      = 4'd15;

    typedef struct packed {
        logic              req_type;
        logic [CLASS_W-1:0] det_class;
        logic [CONF_W-1:0] det_confidence;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic       found_any;
        logic [5:0] participants;
        logic [3:0] top_class;
        logic [3:0] mean_confidence;
        logic [1:0] threat_level;
    } t_out;

    typedef struct packed {
        logic store;      // write ring entry from input data
        logic start;      // clear accumulators, load walk pointer
        logic walk;       // read/process ring entry
        logic scan;       // one vote counter compare
        logic div_start;
        logic div_step;
        logic finish;     // form result
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic scan_done;
        logic div_done;
    } t_sts;

endpackage

FILE: rtl/windowed_detection_vote_fusion.sv
// ----------------------------------------------------------------------------
// windowed_detection_vote_fusion
// Stores detections in a ring and fuses recent ones into a class vote.
// ----------------------------------------------------------------------------
// A store item is written to the ring and gives no result. A correlate item
// holds the input stall through its whole run: a set-up step, the ring
// walk (n entries read, up to the fill count, one read port of the ring
// memory), a scan of the NUM_CLASSES (16) vote counters, the bit-serial
// mean divide (14 steps and a done check) and the load of the result
// register. One item is in work at a time; a finished result also waits
// in place while the previous result has not been taken.
module windowed_detection_vote_fusion #(
    parameter int RING_DEPTH  = 32,
    parameter int NUM_CLASSES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  wdvf_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output wdvf_pkg::t_out                        o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wdvf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wdvf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    wdvf_pkg::t_cmd cmd;
    wdvf_pkg::t_sts sts;
    wdvf_pkg::t_in  r_item;
    wdvf_pkg::t_in  dp_item;
    logic           busy;
    logic           go;
    logic           r_out_valid;
    logic           out_free;

    logic [15:0] r_window_ms;
    logic [5:0]  r_high_vote_min;
    logic [3:0]  r_high_conf_min;
    logic [5:0]  r_medium_vote_min;
    logic [3:0]  r_medium_conf_min;

    assign o_in_stall  = busy;
    assign go          = i_in_valid && !busy;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms       <= 16'd5000;
            r_high_vote_min   <= 6'd3;
            r_high_conf_min   <= 4'd12;
            r_medium_vote_min <= 6'd2;
            r_medium_conf_min <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wdvf_pkg::CFG_WINDOW_MS:       r_window_ms       <= i_cfg_data;
                wdvf_pkg::CFG_HIGH_VOTE_MIN:   r_high_vote_min   <= i_cfg_data[5:0];
                wdvf_pkg::CFG_HIGH_CONF_MIN:   r_high_conf_min   <= i_cfg_data[3:0];
                wdvf_pkg::CFG_MEDIUM_VOTE_MIN: r_medium_vote_min <= i_cfg_data[5:0];
                wdvf_pkg::CFG_MEDIUM_CONF_MIN: r_medium_conf_min <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    wdvf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_req_type (i_in_data.req_type),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    always_comb begin
        dp_item = cmd.store ? i_in_data : r_item;
    end

    wdvf_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (dp_item),
        .i_cmd             (cmd),
        .i_window_ms       (r_window_ms),
        .i_high_vote_min   (r_high_vote_min),
        .i_high_conf_min   (r_high_conf_min),
        .i_medium_vote_min (r_medium_vote_min),
        .i_medium_conf_min (r_medium_conf_min),
        .o_sts             (sts),
        .o_result          (o_out_data)
    );

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(cmd.finish))
        else $error("result without finish");
    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> out_free)
        else $error("result register overwritten");
    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !go)
        else $error("item accepted while busy");
`endif

endmodule

FILE: rtl/wdvf_ctrl.sv
// ----------------------------------------------------------------------------
// wdvf_ctrl
// Sequencer for store, ring walk, vote scan and mean divide.
// ----------------------------------------------------------------------------
module wdvf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic            i_req_type,
    input  logic            i_out_free,
    input  wdvf_pkg::t_sts  i_sts,
    output wdvf_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    if (i_req_type == wdvf_pkg::REQ_STORE) begin
                        o_cmd.store = 1'b1;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |-> r_state == S_IDLE)
        else $error("store outside idle");
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_WALK)
        else $error("start not followed by walk");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("finish not followed by idle");
`endif

endmodule

FILE: rtl/wdvf_dp.sv
// ----------------------------------------------------------------------------
// wdvf_dp
// Ring memory, walk, vote counters, scan, serial divider and result forming.
// ----------------------------------------------------------------------------
module wdvf_dp #(
    parameter int RING_DEPTH  = 32,
    parameter int NUM_CLASSES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wdvf_pkg::t_in   i_item,
    input  wdvf_pkg::t_cmd  i_cmd,
    input  logic [15:0]     i_window_ms,
    input  logic [5:0]      i_high_vote_min,
    input  logic [3:0]      i_high_conf_min,
    input  logic [5:0]      i_medium_vote_min,
    input  logic [3:0]      i_medium_conf_min,
    output wdvf_pkg::t_sts  o_sts,
    output wdvf_pkg::t_out  o_result
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SUM_W  = wdvf_pkg::CONF_W + CNT_W;
    localparam int ENT_W  = wdvf_pkg::CLASS_W + wdvf_pkg::CONF_W + wdvf_pkg::TIME_W;
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(RING_DEPTH - 1);
    localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_CLASSES - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(RING_DEPTH);

    logic [ENT_W-1:0] r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_used;
    logic [PTR_W-1:0] r_wp;
    logic [CNT_W-1:0] r_fill;

    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_left;
    logic             r_rd_vld;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [ENT_W-1:0] r_rd_data;
    logic             r_stop;

    logic [CNT_W-1:0] r_votes [NUM_CLASSES];
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_total;

    logic [CLS_W-1:0] r_scan_idx;
    logic [CLS_W-1:0] r_best;
    logic [CNT_W-1:0] r_best_votes;

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [$clog2(SUM_W+1)-1:0] r_div_cnt;

    logic [3:0]             e_cls;
    logic [7:0]             e_conf;
    logic [31:0]            e_age;
    logic                   e_in_window;
    logic                   e_count;
    logic                   walk_issue;
    logic [SUM_W:0]         rem_shift;
    logic [SUM_W:0]         rem_sub;
    logic [3:0]             mean_c;
    logic [1:0]             level;

    assign e_cls  = r_rd_data[ENT_W-1 -: 4];
    assign e_conf = r_rd_data[wdvf_pkg::TIME_W +: 8];
    assign e_age  = i_item.now_ms - r_rd_data[31:0];
    assign e_in_window = (e_age <= {16'd0, i_window_ms});
    assign e_count = r_rd_vld && !r_stop && e_in_window && !r_used[r_rd_ptr];

    assign walk_issue = i_cmd.walk && (r_left != '0) && !r_stop
                        && !(r_rd_vld && !e_in_window);

    assign n_rp = (r_rp == '0) ? LAST_PTR : r_rp - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_wp] <= {i_item.det_class, i_item.det_confidence, i_item.now_ms};
        end
        if (walk_issue) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_stop   <= 1'b0;
            r_left   <= '0;
        end else begin
            if (i_cmd.store) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
                if (r_fill != DEPTH_CNT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_rp     <= (r_wp == '0) ? LAST_PTR : r_wp - 1'b1;
                r_left   <= r_fill;
                r_rd_vld <= 1'b0;
                r_stop   <= 1'b0;
            end else if (i_cmd.walk) begin
                if (r_rd_vld && !e_in_window) begin
                    r_stop <= 1'b1;
                end
                r_rd_vld <= walk_issue;
                r_rd_ptr <= r_rp;
                if (walk_issue) begin
                    r_rp   <= n_rp;
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd.store) begin
                r_used[r_wp] <= 1'b0;
            end
            if (i_cmd.walk && e_count) begin
                r_used[r_rd_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_votes[k] <= '0;
            end
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.walk && e_count) begin
            if ({28'd0, e_cls} < NUM_CLASSES) begin
                r_votes[CLS_W'(e_cls)] <= r_votes[CLS_W'(e_cls)] + 1'b1;
            end
            r_count <= r_count + 1'b1;
            r_total <= r_total + SUM_W'(e_conf);
        end
    end

    assign o_sts.walk_done = !r_rd_vld && (r_stop || r_left == '0);
    assign o_sts.scan_done = (r_scan_idx == LAST_CLASS);
    assign o_sts.div_done  = (r_div_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan_idx   <= '0;
            r_best       <= '0;
            r_best_votes <= '0;
        end else if (i_cmd.scan) begin
            if (r_votes[r_scan_idx] > r_best_votes) begin
                r_best_votes <= r_votes[r_scan_idx];
                r_best       <= r_scan_idx;
            end
            if (r_scan_idx != LAST_CLASS) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    assign rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub   = rem_shift - (SUM_W+1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= r_total;
            r_div_cnt <= ($clog2(SUM_W+1))'(SUM_W);
        end else if (i_cmd.div_step && r_div_cnt != '0) begin
            if (!rem_sub[SUM_W]) begin
                r_rem <= rem_sub[SUM_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift[SUM_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    assign mean_c = (r_quo > SUM_W'(wdvf_pkg::MEAN_MAX)) ? wdvf_pkg::MEAN_MAX : r_quo[3:0];

    always_comb begin
        if (6'(r_best_votes) >= i_high_vote_min && mean_c >= i_high_conf_min) begin
            level = wdvf_pkg::ALERT_HIGH;
        end else if (6'(r_best_votes) >= i_medium_vote_min
                     && mean_c >= i_medium_conf_min) begin
            level = wdvf_pkg::ALERT_MEDIUM;
        end else begin
            level = wdvf_pkg::ALERT_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_count == '0) begin
                o_result <= '0;
            end else begin
                o_result.found_any       <= 1'b1;
                o_result.participants    <= 6'(r_count);
                o_result.top_class       <= 4'(r_best);
                o_result.mean_confidence <= mean_c;
                o_result.threat_level    <= level;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_CNT)
        else $error("fill count beyond depth");
    a_count_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_count <= r_fill)
        else $error("participants exceed filled entries");
    a_best_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_best_votes <= r_count)
        else $error("winning votes exceed participants");
`endif

endmodule
